[design/tcw_pkg.sv]
// Shared types and constants for the text console writer.
// Item payload structs, opcodes, character codes and cell layout.
// No dependencies.
package tcw_pkg;

    // Opcodes
    localparam logic [2:0] OP_PUT       = 3'd0;
    localparam logic [2:0] OP_BACKSPACE = 3'd1;
    localparam logic [2:0] OP_CLEAR     = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_MOVE      = 3'd4;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // Reset value of the default attribute register
    localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;

    // One screen cell: attribute in the upper byte, character in the lower
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] ch;
    } cell_t;

    // Command item
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [6:0] col;
        logic [4:0] row;
        logic       at_position;
    } cmd_t;

    // Response item
    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } rsp_t;

endpackage

[design/tcw_if.sv]
// Valid/ready channel interfaces of the text console writer.
// Command, response and configuration channels; depends on tcw_pkg.
interface tcw_cmd_if;
    logic          valid;
    logic          ready;
    tcw_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcw_rsp_if;
    logic          valid;
    logic          ready;
    tcw_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/tcw_cell_ram.sv]
// Screen cell store: one write port, one read port with registered data.
// Depends on tcw_pkg for the cell layout.
module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  tcw_pkg::cell_t      wdata,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output tcw_pkg::cell_t      rdata
);

    tcw_pkg::cell_t mem_array [DEPTH];
    tcw_pkg::cell_t rdata_reg;

    // Write and registered read; read data holds when re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/text_console_writer_unit.sv]
// Text console writer: cell store in a one-port-read RAM, cursor in registers.
// A put, backspace, move or no-op passes the execute state, then the done state, which
// loads the output register; a read adds a RAM read state, a scroll moves the rows up
// and blanks the last row, and clear blanks all cells. One item at a time: cmd.ready is
// high only in idle, and the done state waits while the output register is still full.
// Reset: a clearing pass writes zero to all ROWS*COLS cells (cmd.ready low).
module text_console_writer_unit #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    tcw_cfg_if.sink    cfg,
    tcw_cmd_if.sink    cmd,
    tcw_rsp_if.source  rsp
);

    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_BASE = ADDR_W'(CELLS - COLS);
    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t              state_reg,       state_next;
    logic                init_reg,        init_next;
    logic [7:0]          default_attr_reg, default_attr_next;
    logic [COL_W-1:0]    cur_col_reg,     cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg,     cur_row_next;
    logic [ADDR_W-1:0]   fill_reg,        fill_next;
    logic [ADDR_W-1:0]   src_reg,         src_next;
    logic [ADDR_W-1:0]   dst_reg,         dst_next;
    logic                pend_reg,        pend_next;
    logic                scr_reg,         scr_next;
    logic                out_valid_reg,   out_valid_next;
    tcw_pkg::rsp_t       out_reg,         out_next;
    tcw_pkg::cmd_t       cmd_reg;

    // RAM port signals
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    tcw_pkg::cell_t      mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    tcw_pkg::cell_t      mem_rdata;

    // Decode helpers
    logic                cmd_fire;
    logic                col_sat;
    logic                row_sat;
    logic [COL_W-1:0]    pos_col;
    logic [ROW_W-1:0]    pos_row;
    logic [COL_W-1:0]    put_col;
    logic [ROW_W-1:0]    put_row;
    logic [7:0]          put_attr;
    logic [COL_W-1:0]    bs_col;
    logic [ROW_W-1:0]    bs_row;
    logic                at_origin;
    logic [COL_W-1:0]    tgt_col;
    logic [ROW_W-1:0]    tgt_row;
    logic [ADDR_W-1:0]   tgt_addr;
    tcw_pkg::cell_t      blank_cell;

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshakes
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign blank_cell = '{attr: default_attr_reg, ch: tcw_pkg::CH_SPACE};

    // Coordinate saturation for positioned operations
    always_comb
    begin
        col_sat = {2'b00, cmd_reg.col} >= 9'(COLS);
        row_sat = {3'b000, cmd_reg.row} >= 8'(ROWS);
        pos_col = col_sat ? LAST_COL : COL_W'(cmd_reg.col);
        pos_row = row_sat ? LAST_ROW : ROW_W'(cmd_reg.row);
        put_col = cmd_reg.at_position ? pos_col : cur_col_reg;
        put_row = cmd_reg.at_position ? pos_row : cur_row_reg;
        put_attr = (cmd_reg.attribute == 8'd0) ? default_attr_reg : cmd_reg.attribute;
        at_origin = (cur_col_reg == '0) && (cur_row_reg == '0);
        bs_col = (cur_col_reg == '0) ? LAST_COL : cur_col_reg - 1'b1;
        bs_row = (cur_col_reg == '0) ? cur_row_reg - 1'b1 : cur_row_reg;
    end

    // Cell address of the current operation
    always_comb
    begin
        case (cmd_reg.opcode)
            tcw_pkg::OP_PUT:
            begin
                tgt_col = put_col;
                tgt_row = put_row;
            end
            tcw_pkg::OP_BACKSPACE:
            begin
                tgt_col = bs_col;
                tgt_row = bs_row;
            end
            default:
            begin
                tgt_col = pos_col;
                tgt_row = pos_row;
            end
        endcase
        tgt_addr = ADDR_W'(ADDR_W'(tgt_row) * COLS_A + ADDR_W'(tgt_col));
    end

    // Next-state logic
    always_comb
    begin
        state_next        = state_reg;
        init_next         = init_reg;
        default_attr_next = default_attr_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        fill_next         = fill_reg;
        src_next          = src_reg;
        dst_next          = dst_reg;
        pend_next         = pend_reg;
        scr_next          = scr_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_next          = out_reg;
        mem_we            = 1'b0;
        mem_waddr         = tgt_addr;
        mem_wdata         = blank_cell;
        mem_re            = 1'b0;
        mem_raddr         = tgt_addr;

        if (cfg.valid)
        begin
            default_attr_next = cfg.data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                scr_next   = 1'b0;
                state_next = ST_DONE;
                src_next   = COLS_A;
                dst_next   = '0;
                pend_next  = 1'b0;
                case (cmd_reg.opcode)
                    tcw_pkg::OP_PUT:
                    begin
                        // Newline, or a printable at the last column, wraps
                        if (cmd_reg.char_code == tcw_pkg::CH_RETURN)
                        begin
                            cur_col_next = '0;
                            cur_row_next = put_row;
                        end
                        else if (cmd_reg.char_code != tcw_pkg::CH_NEWLINE &&
                                 put_col != LAST_COL)
                        begin
                            cur_col_next = put_col + 1'b1;
                            cur_row_next = put_row;
                        end
                        else
                        begin
                            cur_col_next = '0;
                            if (put_row == LAST_ROW)
                            begin
                                cur_row_next = LAST_ROW;
                                scr_next     = 1'b1;
                                state_next   = ST_SCROLL;
                            end
                            else
                            begin
                                cur_row_next = put_row + 1'b1;
                            end
                        end
                        if (cmd_reg.char_code != tcw_pkg::CH_NEWLINE &&
                            cmd_reg.char_code != tcw_pkg::CH_RETURN)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = '{attr: put_attr, ch: cmd_reg.char_code};
                        end
                    end
                    tcw_pkg::OP_BACKSPACE:
                    begin
                        if (!at_origin)
                        begin
                            cur_col_next = bs_col;
                            cur_row_next = bs_row;
                            mem_we       = 1'b1;
                        end
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        fill_next    = '0;
                        state_next   = ST_FILL;
                    end
                    tcw_pkg::OP_READ:
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_READ;
                    end
                    tcw_pkg::OP_MOVE:
                    begin
                        cur_col_next = pos_col;
                        cur_row_next = pos_row;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_READ:
            begin
                state_next = ST_DONE;
            end

            // Row move: read cell i+COLS, write it to cell i in the next cycle
            ST_SCROLL:
            begin
                mem_re    = 1'b1;
                mem_raddr = src_reg;
                src_next  = src_reg + 1'b1;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                    dst_next  = dst_reg + 1'b1;
                end
                if (src_reg == LAST_ADDR)
                begin
                    state_next = ST_SCROLL_END;
                end
            end

            ST_SCROLL_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = dst_reg;
                mem_wdata  = mem_rdata;
                pend_next  = 1'b0;
                fill_next  = SCROLL_BASE;
                state_next = ST_FILL;
            end

            // Fill sweep: reset pass writes zero, clear and scroll write blanks
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_reg;
                mem_wdata = init_reg ? '0 : blank_cell;
                fill_next = fill_reg + 1'b1;
                if (fill_reg == LAST_ADDR)
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.cursor_col   = 7'(cur_col_reg);
                    out_next.cursor_row   = 5'(cur_row_reg);
                    out_next.scrolled     = scr_reg;
                    if (cmd_reg.opcode == tcw_pkg::OP_READ)
                    begin
                        out_next.cell_char = mem_rdata.ch;
                        out_next.cell_attr = mem_rdata.attr;
                    end
                    else
                    begin
                        out_next.cell_char = 8'd0;
                        out_next.cell_attr = 8'd0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, cursor and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            init_reg         <= 1'b1;
            default_attr_reg <= tcw_pkg::DEFAULT_ATTR_RST;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            fill_reg         <= '0;
            src_reg          <= '0;
            dst_reg          <= '0;
            pend_reg         <= 1'b0;
            scr_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            init_reg         <= init_next;
            default_attr_reg <= default_attr_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            fill_reg         <= fill_next;
            src_reg          <= src_next;
            dst_reg          <= dst_next;
            pend_reg         <= pend_next;
            scr_reg          <= scr_next;
            out_valid_reg    <= out_valid_next;
            out_reg          <= out_next;
        end
    end

    // Accepted command payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg <= cmd.data;
        end
    end

endmodule
